>>> design/rnfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rnfa_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int MIN_CLIENTS = 5;
  localparam int IDX_W = $clog2(MAX_CLIENTS);
  localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_ADD     = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_QUEUED = 2'd1,
    STATUS_REJECT = 2'd2,
    STATUS_BUSY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CS_NONE  = 2'd0,
    CS_THINK = 2'd1,
    CS_WAIT  = 2'd2,
    CS_EAT   = 2'd3
  } cstate_t;

  // address sources for the client state memory
  typedef enum logic [2:0] {
    AS_IDX       = 3'd0,
    AS_LEFT      = 3'd1,
    AS_RIGHT     = 3'd2,
    AS_LEFT2     = 3'd3,
    AS_RIGHT2    = 3'd4,
    AS_COUNT     = 3'd5,
    AS_LAST      = 3'd6,
    AS_PREV_LAST = 3'd7
  } addr_sel_t;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_DECODE,
    FS_CHK_SELF,
    FS_REQ_L,
    FS_REQ_R,
    FS_REL_L,
    FS_REL_LL,
    FS_REL_R_RD,
    FS_REL_R,
    FS_REL_RR,
    FS_REM_A,
    FS_REM_B,
    FS_RESP
  } fsm_state_t;

  typedef struct packed {
    logic      load;
    addr_sel_t rd_sel;
    logic      rd_zero;
    logic      wr_en;
    addr_sel_t wr_sel;
    cstate_t   wr_val;
    logic      set_status;
    status_t   status;
    logic      grant;
    addr_sel_t grant_sel;
    logic      save_eat;
    logic      cnt_inc;
    logic      cnt_dec;
  } dp_cmd_t;

  typedef struct packed {
    op_t     op;
    logic    idx_ok;
    logic    add_ok;
    logic    rem_ok;
    cstate_t rd_val;
    logic    nb_eat;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] ring_left(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] n_m1;
    n_m1 = n - CNT_W'(1);
    return (i == '0) ? n_m1[IDX_W-1:0] : i - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_right(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] i_p1;
    i_p1 = {1'b0, i} + CNT_W'(1);
    return (i_p1 >= n) ? '0 : i_p1[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/rnfa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rnfa_datapath
  import rnfa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       op,
  input  wire logic [IDX_W-1:0] client_index,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  output logic [1:0]            status,
  output logic                  first_grant_valid,
  output logic [IDX_W-1:0]      first_grant_index,
  output logic                  second_grant_valid,
  output logic [IDX_W-1:0]      second_grant_index,
  output logic [CNT_W-1:0]      client_count
);

  op_t              op_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] seated_count;
  cstate_t          mem [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] vld;
  cstate_t          rd_val;
  logic             nb_eat;
  status_t          status_q;
  logic             g1v;
  logic [IDX_W-1:0] g1i;
  logic             g2v;
  logic [IDX_W-1:0] g2i;

  logic [IDX_W-1:0] addr_tab [8];
  logic [IDX_W-1:0] left_a;
  logic [IDX_W-1:0] right_a;
  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] n_m2;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] grant_addr;
  cstate_t          rst_val;

  always_comb begin
    left_a  = ring_left(idx_q, seated_count);
    right_a = ring_right(idx_q, seated_count);
    n_m1    = seated_count - CNT_W'(1);
    n_m2    = seated_count - CNT_W'(2);
    addr_tab[AS_IDX]       = idx_q;
    addr_tab[AS_LEFT]      = left_a;
    addr_tab[AS_RIGHT]     = right_a;
    addr_tab[AS_LEFT2]     = ring_left(left_a, seated_count);
    addr_tab[AS_RIGHT2]    = ring_right(right_a, seated_count);
    addr_tab[AS_COUNT]     = seated_count[IDX_W-1:0];
    addr_tab[AS_LAST]      = n_m1[IDX_W-1:0];
    addr_tab[AS_PREV_LAST] = n_m2[IDX_W-1:0];
    rd_addr    = cmd.rd_zero ? '0 : addr_tab[cmd.rd_sel];
    wr_addr    = addr_tab[cmd.wr_sel];
    grant_addr = addr_tab[cmd.grant_sel];
    rst_val    = ({1'b0, rd_addr} < CNT_W'(MIN_CLIENTS)) ? CS_THINK : CS_NONE;
  end

  // entries never written read back as their reset value
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_val;
    end
    rd_val <= vld[rd_addr] ? mem[rd_addr] : rst_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      seated_count <= CNT_W'(MIN_CLIENTS);
    end else begin
      if (cmd.wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (cmd.cnt_inc) begin
        seated_count <= seated_count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        seated_count <= n_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op_t'(op);
      idx_q    <= client_index;
      status_q <= STATUS_REJECT;
      g1v      <= 1'b0;
      g1i      <= '0;
      g2v      <= 1'b0;
      g2i      <= '0;
    end else begin
      if (cmd.set_status) begin
        status_q <= cmd.status;
      end
      if (cmd.grant) begin
        if (g1v) begin
          g2v <= 1'b1;
          g2i <= grant_addr;
        end else begin
          g1v <= 1'b1;
          g1i <= grant_addr;
        end
      end
    end
    if (cmd.save_eat) begin
      nb_eat <= (rd_val == CS_EAT);
    end
  end

  always_comb begin
    stat.op     = op_q;
    stat.idx_ok = ({1'b0, idx_q} < seated_count);
    stat.add_ok = (seated_count < CNT_W'(MAX_CLIENTS));
    stat.rem_ok = (seated_count > CNT_W'(MIN_CLIENTS));
    stat.rd_val = rd_val;
    stat.nb_eat = nb_eat;
  end

  assign status             = status_q;
  assign first_grant_valid  = g1v;
  assign first_grant_index  = g1i;
  assign second_grant_valid = g2v;
  assign second_grant_index = g2i;
  assign client_count       = seated_count;

endmodule

`default_nettype wire

>>> design/rnfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rnfa_ctrl
  import rnfa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy,
  output logic          done
);

  fsm_state_t state;
  fsm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = AS_IDX;
    cmd.wr_sel    = AS_IDX;
    cmd.wr_val    = CS_NONE;
    cmd.status    = STATUS_DONE;
    cmd.grant_sel = AS_IDX;
    state_next    = state;
    busy          = (state != FS_IDLE);
    done          = (state == FS_RESP);

    unique case (state)
      FS_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = FS_DECODE;
        end
      end
      FS_DECODE: begin
        state_next = FS_RESP;
        unique case (stat.op) inside
          OP_REQUEST, OP_RELEASE: begin
            if (stat.idx_ok) begin
              cmd.rd_sel = AS_IDX;
              state_next = FS_CHK_SELF;
            end
          end
          OP_ADD: begin
            if (stat.add_ok) begin
              cmd.wr_en      = 1'b1;
              cmd.wr_sel     = AS_COUNT;
              cmd.wr_val     = CS_THINK;
              cmd.cnt_inc    = 1'b1;
              cmd.set_status = 1'b1;
              cmd.status     = STATUS_DONE;
            end
          end
          OP_REMOVE: begin
            if (stat.rem_ok) begin
              cmd.rd_sel = AS_PREV_LAST;
              state_next = FS_REM_A;
            end
          end
          default: state_next = FS_RESP;
        endcase
      end
      FS_CHK_SELF: begin
        state_next = FS_RESP;
        if (stat.op == OP_REQUEST) begin
          if (stat.rd_val == CS_THINK) begin
            cmd.rd_sel = AS_LEFT;
            state_next = FS_REQ_L;
          end
        end else if (stat.rd_val == CS_EAT) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = AS_IDX;
          cmd.wr_val     = CS_THINK;
          cmd.set_status = 1'b1;
          cmd.status     = STATUS_DONE;
          cmd.rd_sel     = AS_LEFT;
          state_next     = FS_REL_L;
        end
      end
      FS_REQ_L: begin
        cmd.save_eat = 1'b1;
        cmd.rd_sel   = AS_RIGHT;
        state_next   = FS_REQ_R;
      end
      FS_REQ_R: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = AS_IDX;
        cmd.set_status = 1'b1;
        if (stat.nb_eat || stat.rd_val == CS_EAT) begin
          cmd.wr_val = CS_WAIT;
          cmd.status = STATUS_QUEUED;
        end else begin
          cmd.wr_val    = CS_EAT;
          cmd.status    = STATUS_DONE;
          cmd.grant     = 1'b1;
          cmd.grant_sel = AS_IDX;
        end
        state_next = FS_RESP;
      end
      FS_REL_L: begin
        if (stat.rd_val == CS_WAIT) begin
          cmd.rd_sel = AS_LEFT2;
          state_next = FS_REL_LL;
        end else begin
          state_next = FS_REL_R_RD;
        end
      end
      FS_REL_LL: begin
        if (stat.rd_val != CS_EAT) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = AS_LEFT;
          cmd.wr_val    = CS_EAT;
          cmd.grant     = 1'b1;
          cmd.grant_sel = AS_LEFT;
        end
        state_next = FS_REL_R_RD;
      end
      FS_REL_R_RD: begin
        cmd.rd_sel = AS_RIGHT;
        state_next = FS_REL_R;
      end
      FS_REL_R: begin
        if (stat.rd_val == CS_WAIT) begin
          cmd.rd_sel = AS_RIGHT2;
          state_next = FS_REL_RR;
        end else begin
          state_next = FS_RESP;
        end
      end
      FS_REL_RR: begin
        if (stat.rd_val != CS_EAT) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = AS_RIGHT;
          cmd.wr_val    = CS_EAT;
          cmd.grant     = 1'b1;
          cmd.grant_sel = AS_RIGHT;
        end
        state_next = FS_RESP;
      end
      FS_REM_A: begin
        cmd.save_eat = 1'b1;
        cmd.rd_zero  = 1'b1;
        state_next   = FS_REM_B;
      end
      FS_REM_B: begin
        cmd.set_status = 1'b1;
        if (stat.nb_eat && stat.rd_val == CS_EAT) begin
          cmd.status = STATUS_BUSY;
        end else begin
          cmd.status  = STATUS_DONE;
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = AS_LAST;
          cmd.wr_val  = CS_NONE;
          cmd.cnt_dec = 1'b1;
        end
        state_next = FS_RESP;
      end
      FS_RESP: begin
        state_next = FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/ring_neighbor_fork_arbiter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ring arbiter for clients sharing resources with their two ring neighbors.
// Command channel: drive op and client_index with start high; the
// transaction is taken at an edge where start is high and busy is low.
// Busy stays high until the result has been shown.
// Result channel: done is high for exactly one cycle while status, the
// grant fields and client_count are valid; the receiver cannot stall it.
// Client states live in a 16 x 2-bit memory with one read and one write
// port, so neighbors are looked up one per cycle by the sequencer.
// Requests and releases for an unseated index or for a client in the wrong
// state are rejected. A new transaction is taken at the earliest in the
// cycle after done, so a transaction is finished before the next is taken.
// Reset (synchronous, rst high): the first 5 clients are thinking, the
// seated count is 5, no result is pending; memory entries that were never
// written read as their reset value through per-entry valid bits.
module ring_neighbor_fork_arbiter_core
  import rnfa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       op,
  input  wire logic [IDX_W-1:0] client_index,
  output logic                  done,
  output logic [1:0]            status,
  output logic                  first_grant_valid,
  output logic [IDX_W-1:0]      first_grant_index,
  output logic                  second_grant_valid,
  output logic [IDX_W-1:0]      second_grant_index,
  output logic [CNT_W-1:0]      client_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rnfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  rnfa_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .op                 (op),
    .client_index       (client_index),
    .cmd                (cmd),
    .stat               (stat),
    .status             (status),
    .first_grant_valid  (first_grant_valid),
    .first_grant_index  (first_grant_index),
    .second_grant_valid (second_grant_valid),
    .second_grant_index (second_grant_index),
    .client_count       (client_count)
  );

endmodule

`default_nettype wire

>>> design/rnfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rnfa_checker
  import rnfa_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire logic [1:0]       status,
  input wire logic             first_grant_valid,
  input wire logic             second_grant_valid,
  input wire logic [CNT_W-1:0] client_count
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !done)
    else $error("result strobe outside busy or longer than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> client_count >= CNT_W'(MIN_CLIENTS) && client_count <= CNT_W'(MAX_CLIENTS))
    else $error("client count out of range");

  a_second_grant: assert property (@(posedge clk) disable iff (rst)
    done && second_grant_valid |-> first_grant_valid && status == STATUS_DONE)
    else $error("second grant without first grant");

  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    done && first_grant_valid |-> status == STATUS_DONE)
    else $error("grant reported with failing status");

endmodule

bind ring_neighbor_fork_arbiter_core rnfa_checker u_rnfa_checker (.*);

`default_nettype wire
